>>> src/cpbf_pkg.sv
// ----------------------------------------------------------------------------
// cpbf_pkg
// shared types and widths of the brute-force closest pair unit
// ----------------------------------------------------------------------------
`default_nettype none

package cpbf_pkg;

    localparam int COORD_W  = 15;
    localparam int SQ_W     = 30;   // one squared coordinate difference
    localparam int DIST_W   = 31;   // sum of two squares
    localparam int S_DATA_W = 32;   // x, y, padded to bytes
    localparam int M_DATA_W = 96;   // dist, two points, padded to bytes
    localparam int M_USED_W = DIST_W + 4 * COORD_W;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_point;

    typedef struct packed {
        t_point b;  // later point
        t_point a;  // earlier point
    } t_pair;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_ROW   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

>>> src/cpbf_dist_pipe.sv
// ----------------------------------------------------------------------------
// cpbf_dist_pipe
// squared euclidean distance of a point pair, squares registered
// ----------------------------------------------------------------------------
`default_nettype none

module cpbf_dist_pipe (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire cpbf_pkg::t_pair         i_pair,
    output logic                         o_valid,
    output logic [cpbf_pkg::DIST_W-1:0]  o_dist,
    output cpbf_pkg::t_pair              o_pair
);

    logic signed [cpbf_pkg::COORD_W:0]     w_dx;
    logic signed [cpbf_pkg::COORD_W:0]     w_dy;
    logic signed [2*cpbf_pkg::COORD_W+1:0] w_px;
    logic signed [2*cpbf_pkg::COORD_W+1:0] w_py;

    logic                        r_valid;
    logic [cpbf_pkg::SQ_W-1:0]   r_sq_x;
    logic [cpbf_pkg::SQ_W-1:0]   r_sq_y;
    cpbf_pkg::t_pair             r_pair;

    assign w_dx = {i_pair.a.x[cpbf_pkg::COORD_W-1], i_pair.a.x}
                - {i_pair.b.x[cpbf_pkg::COORD_W-1], i_pair.b.x};
    assign w_dy = {i_pair.a.y[cpbf_pkg::COORD_W-1], i_pair.a.y}
                - {i_pair.b.y[cpbf_pkg::COORD_W-1], i_pair.b.y};
    assign w_px = w_dx * w_dx;
    assign w_py = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        // |dx| < 2^15, so the square fits 30 bits
        r_sq_x <= w_px[cpbf_pkg::SQ_W-1:0];
        r_sq_y <= w_py[cpbf_pkg::SQ_W-1:0];
        r_pair <= i_pair;
    end

    assign o_valid = r_valid;
    assign o_dist  = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign o_pair  = r_pair;

endmodule

`default_nettype wire

>>> src/closest_pair_brute_force_unit.sv
// ----------------------------------------------------------------------------
// closest_pair_brute_force_unit
// loads a point set, then searches all pairs for the smallest squared distance
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  s_axis    in   tdata: x_coord, y_coord; tlast: last_point
//  m_axis    out  tdata: min_dist_sq, first/second point; tuser: found
//
//  points load at one beat per cycle into a one-port-read point memory
//  after the last point the pair search reads one stored point per cycle:
//  each row point, then the later points of that row, then drain and result
//  the memory read port is the limit: each pair costs one read
//  reset clears control state only, the point memory needs no clearing
//  a stalled result sits in the output register while the next set loads
//
`default_nettype none

module closest_pair_brute_force_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // x_coord [14:0], y_coord [29:15], zero [31:30]
    input  wire  [cpbf_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  wire                            s_axis_tlast,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // min_dist_sq [30:0], first_x [45:31], first_y [60:46],
    // second_x [75:61], second_y [90:76], zero [95:91]
    output logic [cpbf_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // found [0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    // point memory, {y, x} per entry
    cpbf_pkg::t_point r_mem [MAX_POINTS];
    cpbf_pkg::t_point r_rdata;
    cpbf_pkg::t_point r_pi;       // point of the current row

    cpbf_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_i, n_i;
    logic [IW-1:0]    r_j, n_j;
    logic             r_rd_i;     // read data this cycle is the row point
    logic             r_rd_j;     // read data this cycle is a column point
    logic             r_found, n_found;

    logic [cpbf_pkg::DIST_W-1:0] r_best, n_best;
    cpbf_pkg::t_pair             r_best_pair, n_best_pair;

    logic                        r_out_valid;
    logic                        r_out_found;
    logic [cpbf_pkg::M_DATA_W-1:0] r_out_data;

    logic                        w_in_beat;
    logic                        w_we;
    logic [IW-1:0]               w_raddr;
    logic                        w_row_end;
    logic                        w_more_rows;
    logic                        w_out_free;
    cpbf_pkg::t_point            w_in_pt;
    cpbf_pkg::t_pair             w_cmp_pair;

    logic                        w_d_valid;
    logic [cpbf_pkg::DIST_W-1:0] w_d_dist;
    cpbf_pkg::t_pair             w_d_pair;

    assign s_axis_tready = (r_state == cpbf_pkg::ST_LOAD);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_we          = w_in_beat && (r_count < MAX_CNT);
    assign w_in_pt.x     = s_axis_tdata[cpbf_pkg::COORD_W-1:0];
    assign w_in_pt.y     = s_axis_tdata[2*cpbf_pkg::COORD_W-1:cpbf_pkg::COORD_W];

    assign w_raddr     = (r_state == cpbf_pkg::ST_SCAN) ? r_j : r_i;
    // last column of the row, and whether row i+1 still has a pair
    assign w_row_end   = (CW'(r_j) == r_count - CW'(1));
    assign w_more_rows = ((CW'(r_i) + CW'(2)) < r_count);
    assign w_out_free  = !r_out_valid || m_axis_tready;

    // point memory: one write port while loading, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[IW-1:0]] <= w_in_pt;
        end
        r_rdata <= r_mem[w_raddr];
        if (r_rd_i) begin
            r_pi <= r_rdata;
        end
    end

    assign w_cmp_pair.a = r_pi;
    assign w_cmp_pair.b = r_rdata;

    cpbf_dist_pipe u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_j),
        .i_pair  (w_cmp_pair),
        .o_valid (w_d_valid),
        .o_dist  (w_d_dist),
        .o_pair  (w_d_pair)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_found     = r_found;
        n_best      = r_best;
        n_best_pair = r_best_pair;

        // pairs arrive in row-major order; strict compare keeps the first tie
        if (w_d_valid && (w_d_dist < r_best)) begin
            n_best      = w_d_dist;
            n_best_pair = w_d_pair;
        end

        case (r_state)
            cpbf_pkg::ST_LOAD: begin
                if (w_in_beat) begin
                    if (r_count < MAX_CNT) begin
                        n_count = r_count + CW'(1);
                    end
                    if (s_axis_tlast) begin
                        n_best  = '1;
                        n_i     = '0;
                        n_found = (n_count >= CW'(2));
                        n_state = (n_count >= CW'(2)) ? cpbf_pkg::ST_ROW
                                                      : cpbf_pkg::ST_EMIT;
                    end
                end
            end
            cpbf_pkg::ST_ROW: begin
                n_j     = r_i + IW'(1);
                n_state = cpbf_pkg::ST_SCAN;
            end
            cpbf_pkg::ST_SCAN: begin
                if (w_row_end) begin
                    if (w_more_rows) begin
                        n_i     = r_i + IW'(1);
                        n_state = cpbf_pkg::ST_ROW;
                    end else begin
                        n_state = cpbf_pkg::ST_DRAIN;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            cpbf_pkg::ST_DRAIN: begin
                if (!r_rd_j && !w_d_valid) begin
                    n_state = cpbf_pkg::ST_EMIT;
                end
            end
            cpbf_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_count = '0;
                    n_state = cpbf_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = cpbf_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpbf_pkg::ST_LOAD;
            r_count     <= '0;
            r_rd_i      <= 1'b0;
            r_rd_j      <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_best      <= '1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_i  <= (r_state == cpbf_pkg::ST_ROW);
            r_rd_j  <= (r_state == cpbf_pkg::ST_SCAN);
            r_found <= n_found;
            r_best  <= n_best;
            if ((r_state == cpbf_pkg::ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_i         <= n_i;
        r_j         <= n_j;
        r_best_pair <= n_best_pair;
        if ((r_state == cpbf_pkg::ST_EMIT) && w_out_free) begin
            r_out_found <= r_found;
            if (r_found) begin
                r_out_data <= {{(cpbf_pkg::M_DATA_W - cpbf_pkg::M_USED_W){1'b0}},
                               r_best_pair.b.y, r_best_pair.b.x,
                               r_best_pair.a.y, r_best_pair.a.x, r_best};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_found;

    // the fill count never passes the memory depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("point count beyond memory depth");

    // the column index always lies past the row index while scanning
    a_j_after_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpbf_pkg::ST_SCAN) |-> (r_j > r_i))
        else $error("column index not past row index");

    // a scanned column stays inside the loaded set
    a_j_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpbf_pkg::ST_SCAN) |-> (CW'(r_j) < r_count))
        else $error("column index outside loaded set");

    // a result without a pair carries zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty result with nonzero data");

    // no distance beat is left in flight when the result is formed
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpbf_pkg::ST_EMIT) |-> (!w_d_valid && !r_rd_j))
        else $error("result formed with distances in flight");

endmodule

`default_nettype wire
